>>> sv/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Holds default geometry, control character codes, the item and result
// records and the sequencer state codes; depends on nothing.
package tcw_pkg;

  // Default geometry, handed to the top-level parameters
  localparam int DEF_SCREEN_COLUMNS = 80;
  localparam int DEF_SCREEN_ROWS    = 25;
  localparam int DEF_TAB_STOP       = 4;

  // Character codes treated specially by put mode, and the space used for blanks
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // Attribute byte after reset
  localparam logic [7:0] RESET_ATTR = 8'h0F;

  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_SET   = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] char_code;
    logic [10:0] cell_index;
    logic [7:0] target_column;
    logic [7:0] target_row;
  } item_t;

  typedef struct packed {
    logic [15:0] read_cell;
    logic [10:0] cursor_position;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PUT,
    ST_TAB,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } eng_state_t;

  // What follows a scroll or a fill sweep
  typedef enum logic [1:0] {
    PEND_DONE,
    PEND_TAB,
    PEND_CHAR,
    PEND_IDLE
  } pend_t;

endpackage

>>> sv/tcw_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Stands alone; depends on nothing.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/tcw_engine.sv
// Console sequencer: cursor registers and the read-modify-write walk over
// the screen store. Depends on tcw_pkg; drives the ports of one tcw_ram.
module tcw_engine
  import tcw_pkg::*;
#(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS,
  parameter int TAB_STOP       = DEF_TAB_STOP,
  localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS,
  localparam int ADDR_W     = $clog2(CELL_COUNT)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start_i,
  input  item_t             item_i,
  input  logic [7:0]        attr_i,
  output logic              idle_o,
  output logic              done_o,
  output result_t           res_o,
  input  logic              ack_i,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_waddr,
  output logic [15:0]       mem_wdata,
  output logic              mem_re,
  output logic [ADDR_W-1:0] mem_raddr,
  input  logic [15:0]       mem_rdata
);

  localparam int COL_W  = $clog2(SCREEN_COLUMNS + 1);
  localparam int LINE_W = $clog2(SCREEN_ROWS);
  localparam int POS_W  = $clog2(CELL_COUNT + 1);
  localparam int PTR_W  = POS_W;
  // Reciprocal of the tab stop in 16 fractional bits, rounded up
  localparam int TAB_RECIP = ((1 << 16) + TAB_STOP - 1) / TAB_STOP;
  localparam int PROD_W    = COL_W + 17;

  eng_state_t        state_r, state_nxt;
  pend_t             pend_r, pend_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic [ADDR_W-1:0] fill_ptr_r, fill_ptr_nxt;
  logic [15:0]       fill_word_r, fill_word_nxt;
  logic [7:0]        put_ch_r, put_ch_nxt;
  logic              adv_r, adv_nxt;
  logic [15:0]       cell_r, cell_nxt;
  logic              in_range_r, in_range_nxt;

  logic [POS_W-1:0]      pos;
  logic [POS_W+10:0]     pos_ext;
  logic [ADDR_W+10:0]    idx_ext;
  logic                  last_line;
  logic [COL_W-1:0]      col_inc;
  logic [PROD_W-1:0]     tab_prod;
  logic                  tab_hit;
  logic                  go_line;
  pend_t                 after_line;

  function automatic eng_state_t pend_state(pend_t p);
    eng_state_t s;
    case (p)
      PEND_TAB:  s = ST_TAB;
      PEND_CHAR: s = ST_PUT;
      PEND_IDLE: s = ST_IDLE;
      default:   s = ST_DONE;
    endcase
    return s;
  endfunction

  assign pos       = POS_W'(line_r) * POS_W'(SCREEN_COLUMNS) + POS_W'(col_r);
  assign pos_ext   = {11'b0, pos};
  assign idx_ext   = {{ADDR_W{1'b0}}, item_i.cell_index};
  assign last_line = (line_r == LINE_W'(SCREEN_ROWS - 1));
  assign col_inc   = col_r + 1'b1;

  // Tab stop test: with col = q*T + r, the low 16 bits of col * recip stay
  // below recip exactly when r is zero.
  assign tab_prod = PROD_W'(col_inc) * PROD_W'(TAB_RECIP);
  assign tab_hit  = ({1'b0, tab_prod[15:0]} < 17'(TAB_RECIP));

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    col_nxt       = col_r;
    line_nxt      = line_r;
    rd_ptr_nxt    = rd_ptr_r;
    rd_pend_nxt   = 1'b0;
    fill_ptr_nxt  = fill_ptr_r;
    fill_word_nxt = fill_word_r;
    put_ch_nxt    = put_ch_r;
    adv_nxt       = adv_r;
    cell_nxt      = cell_r;
    in_range_nxt  = in_range_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    go_line       = 1'b0;
    after_line    = PEND_DONE;

    case (state_r)
      ST_IDLE: begin
        if (start_i) begin
          cell_nxt = '0;
          case (item_i.mode)
            MODE_PUT: begin
              case (item_i.char_code)
                CH_NUL: begin
                  state_nxt = ST_DONE;
                end
                CH_NEWLINE: begin
                  go_line    = 1'b1;
                  after_line = PEND_DONE;
                end
                CH_RETURN: begin
                  col_nxt   = '0;
                  state_nxt = ST_DONE;
                end
                CH_TAB: begin
                  put_ch_nxt = CH_SPACE;
                  if (col_r >= COL_W'(SCREEN_COLUMNS)) begin
                    go_line    = 1'b1;
                    after_line = PEND_TAB;
                  end else begin
                    state_nxt = ST_TAB;
                  end
                end
                CH_BACKSPACE: begin
                  put_ch_nxt = CH_SPACE;
                  adv_nxt    = 1'b0;
                  if (col_r != '0) begin
                    col_nxt = col_r - 1'b1;
                  end else if (line_r != '0) begin
                    line_nxt = line_r - 1'b1;
                    col_nxt  = COL_W'(SCREEN_COLUMNS - 1);
                  end
                  state_nxt = ST_PUT;
                end
                default: begin
                  put_ch_nxt = item_i.char_code;
                  adv_nxt    = 1'b1;
                  if (col_r >= COL_W'(SCREEN_COLUMNS)) begin
                    go_line    = 1'b1;
                    after_line = PEND_CHAR;
                  end else begin
                    state_nxt = ST_PUT;
                  end
                end
              endcase
            end
            MODE_READ: begin
              in_range_nxt = (idx_ext < (ADDR_W + 11)'(CELL_COUNT));
              mem_re       = 1'b1;
              mem_raddr    = idx_ext[ADDR_W-1:0];
              state_nxt    = ST_READ;
            end
            MODE_SET: begin
              col_nxt  = (item_i.target_column >= 8'(SCREEN_COLUMNS)) ?
                         COL_W'(SCREEN_COLUMNS - 1) : COL_W'(item_i.target_column);
              line_nxt = (item_i.target_row >= 8'(SCREEN_ROWS)) ?
                         LINE_W'(SCREEN_ROWS - 1) : LINE_W'(item_i.target_row);
              state_nxt = ST_DONE;
            end
            default: begin
              col_nxt       = '0;
              line_nxt      = '0;
              fill_ptr_nxt  = '0;
              fill_word_nxt = {attr_i, CH_SPACE};
              pend_nxt      = PEND_DONE;
              state_nxt     = ST_FILL;
            end
          endcase
        end
      end

      ST_READ: begin
        cell_nxt  = in_range_r ? mem_rdata : '0;
        state_nxt = ST_DONE;
      end

      ST_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos[ADDR_W-1:0];
        mem_wdata = {attr_i, put_ch_r};
        if (adv_r) begin
          col_nxt = col_inc;
        end
        state_nxt = ST_DONE;
      end

      ST_TAB: begin
        mem_we    = 1'b1;
        mem_waddr = pos[ADDR_W-1:0];
        mem_wdata = {attr_i, CH_SPACE};
        col_nxt   = col_inc;
        if (col_inc >= COL_W'(SCREEN_COLUMNS) || tab_hit) begin
          state_nxt = ST_DONE;
        end
      end

      ST_SCROLL: begin
        // Write back the row-below cell fetched last cycle, one row up
        if (rd_pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = ADDR_W'(rd_ptr_r - PTR_W'(SCREEN_COLUMNS + 1));
          mem_wdata = mem_rdata;
        end
        if (rd_ptr_r != PTR_W'(CELL_COUNT)) begin
          mem_re      = 1'b1;
          mem_raddr   = rd_ptr_r[ADDR_W-1:0];
          rd_ptr_nxt  = rd_ptr_r + 1'b1;
          rd_pend_nxt = 1'b1;
        end else begin
          fill_ptr_nxt  = ADDR_W'(CELL_COUNT - SCREEN_COLUMNS);
          fill_word_nxt = {attr_i, CH_SPACE};
          state_nxt     = ST_FILL;
        end
      end

      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_ptr_r;
        mem_wdata = fill_word_r;
        if (fill_ptr_r == ADDR_W'(CELL_COUNT - 1)) begin
          state_nxt = pend_state(pend_r);
        end else begin
          fill_ptr_nxt = fill_ptr_r + 1'b1;
        end
      end

      ST_DONE: begin
        if (ack_i) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Advance to the next line, or scroll from the bottom one
    if (go_line) begin
      col_nxt = '0;
      if (!last_line) begin
        line_nxt  = line_r + 1'b1;
        state_nxt = pend_state(after_line);
      end else begin
        pend_nxt    = after_line;
        rd_ptr_nxt  = PTR_W'(SCREEN_COLUMNS);
        rd_pend_nxt = 1'b0;
        state_nxt   = ST_SCROLL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      pend_r      <= PEND_IDLE;
      col_r       <= '0;
      line_r      <= '0;
      rd_ptr_r    <= '0;
      rd_pend_r   <= 1'b0;
      fill_ptr_r  <= '0;
      fill_word_r <= {RESET_ATTR, CH_SPACE};
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      col_r       <= col_nxt;
      line_r      <= line_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      rd_pend_r   <= rd_pend_nxt;
      fill_ptr_r  <= fill_ptr_nxt;
      fill_word_r <= fill_word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    put_ch_r   <= put_ch_nxt;
    adv_r      <= adv_nxt;
    cell_r     <= cell_nxt;
    in_range_r <= in_range_nxt;
  end

  assign idle_o                = (state_r == ST_IDLE);
  assign done_o                = (state_r == ST_DONE);
  assign res_o.read_cell       = cell_r;
  assign res_o.cursor_position = pos_ext[10:0];

endmodule

>>> sv/text_console_writer.sv
// Top level of the text console writer: channel handshakes, attribute
// register and result register. Depends on tcw_pkg, tcw_ram and tcw_engine.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------
//   in_     | input     | in_valid / in_ready    | mode, char_code, cell_index,
//           |           |                        | target_column, target_row
//   out_    | output    | out_valid / out_ready  | read_cell, cursor_position
//   cfg_    | input     | cfg_valid / cfg_ready  | cfg_data (text attribute)
//
// The screen store has a single write port. A tab writes spaces up to the next
// tab stop (at most TAB_STOP), and a clear rewrites every cell. A newline, or a
// character or tab past the last column, on the last line adds a scroll (row
// copy with one read and one write a cycle, then a blank of the bottom row).
// After reset all CELL_COUNT cells of the store (2000 at the default geometry)
// are swept to spaces; in_ready stays low for that sweep, cfg is taken.
// A finished result waits in the output register; the next transaction is
// accepted meanwhile, and the sequencer holds its own result if both are full.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS,
  parameter int TAB_STOP       = DEF_TAB_STOP
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_char_code,
  input  logic [10:0] in_cell_index,
  input  logic [7:0]  in_target_column,
  input  logic [7:0]  in_target_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_read_cell,
  output logic [10:0] out_cursor_position,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  logic [7:0]        attr_r, attr_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_res_r;
  item_t             item;
  result_t           eng_res;
  logic              eng_idle;
  logic              eng_done;
  logic              start;
  logic              take;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [15:0]       mem_rdata;

  // Gather the input transaction into one record
  assign item.mode          = mode_t'(in_mode);
  assign item.char_code     = in_char_code;
  assign item.cell_index    = in_cell_index;
  assign item.target_column = in_target_column;
  assign item.target_row    = in_target_row;

  // Accept whenever the sequencer is idle; the output register decouples
  assign in_ready = eng_idle;
  assign start    = in_valid & in_ready;

  // Move a finished result into the output register once it has room
  assign take          = eng_done & (~out_valid_r | out_ready);
  assign out_valid_nxt = take | (out_valid_r & ~out_ready);

  // Attribute writes must arrive only while idle; the block does not enforce this and is always ready
  assign cfg_ready = 1'b1;
  assign attr_nxt  = (cfg_valid & cfg_ready) ? cfg_data : attr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= RESET_ATTR;
      out_valid_r <= 1'b0;
    end else begin
      attr_r      <= attr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res_r <= eng_res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_read_cell       = out_res_r.read_cell;
  assign out_cursor_position = out_res_r.cursor_position;

  tcw_engine #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS),
    .TAB_STOP       (TAB_STOP)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (start),
    .item_i    (item),
    .attr_i    (attr_r),
    .idle_o    (eng_idle),
    .done_o    (eng_done),
    .res_o     (eng_res),
    .ack_i     (take),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Screen store: one 16-bit word per character cell
  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
